/* hw/rtl/mcalu_pkg.sv */
// ----------------------------------------------------------------------------
// mcalu_pkg: shared types for the 16-bit add/shift ALU
// Operation codes and the condition flag record.
// ----------------------------------------------------------------------------
package mcalu_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CountW = 6;

  typedef enum logic [OpW-1:0] {
    OP_ADC       = 3'd0,
    OP_ADC_BYTE  = 3'd1,
    OP_ADD       = 3'd2,
    OP_SHIFT_CNT = 3'd3,
    OP_SHIFT_L   = 3'd4,
    OP_SHIFT_R   = 3'd5
  } op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  localparam logic [WordW-1:0] WordMax  = 16'o177777;
  localparam logic [WordW-1:0] WordSMax = 16'o077777;
  localparam logic [7:0]       ByteMax  = 8'o377;
  localparam logic [7:0]       ByteSMax = 8'o177;

endpackage

/* hw/rtl/mcalu_if.sv */
// ----------------------------------------------------------------------------
// mcalu_req_if / mcalu_rsp_if: request and response channels
// Valid/ready handshake; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface mcalu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] dest_word;
  logic [15:0] src_word;
  logic        byte_high;

  modport source (output valid, req_type, dest_word, src_word, byte_high, input ready);
  modport sink   (input valid, req_type, dest_word, src_word, byte_high, output ready);
endinterface

interface mcalu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_word;
  logic        n_flag;
  logic        z_flag;
  logic        v_flag;
  logic        c_flag;

  modport source (output valid, result_word, n_flag, z_flag, v_flag, c_flag, input ready);
  modport sink   (input valid, result_word, n_flag, z_flag, v_flag, c_flag, output ready);
endinterface

/* hw/rtl/minicomputer_add_shift_alu_flags.sv */
// Path: an accepted request passes the input register, then the result register;
//   a response stall holds a finished result in the result register.
// Throughput: one request per cycle unless the response stalls; carry feeds back
//   through the flag register, updated as each request enters the result register.
// Reset: flags clear, both stages empty; request ready comes up right after reset.
// ----------------------------------------------------------------------------
// minicomputer_add_shift_alu_flags: 16-bit ALU with N, Z, V, C flags
// Add-carry (word and byte), add, shift by signed count, shift left/right.
// ----------------------------------------------------------------------------
module minicomputer_add_shift_alu_flags
  import mcalu_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  mcalu_req_if.sink     req_i,
  mcalu_rsp_if.source   rsp_o
);

  // input stage
  logic             s1_valid_q;
  logic [OpW-1:0]   s1_type_q;
  logic [WordW-1:0] s1_dest_q;
  logic [WordW-1:0] s1_src_q;
  logic             s1_hi_q;

  // result stage
  logic             out_valid_q;
  logic [WordW-1:0] out_word_q;
  flags_t           out_flags_q;

  flags_t           flags_q, flags_d;
  logic [WordW-1:0] res_d;

  logic out_free, advance, req_fire;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_type_q <= req_i.req_type;
      s1_dest_q <= req_i.dest_word;
      s1_src_q  <= req_i.src_word;
      s1_hi_q   <= req_i.byte_high;
    end
  end

  // ALU datapath
  logic             cin;
  logic [WordW:0]   sum;
  logic [7:0]       b_in, b_out;
  logic [CountW-1:0] cnt, n_sh;
  logic             right;
  logic [2*WordW-1:0] ext, win_mask, win;
  logic [WordW-1:0] shl, shr;
  logic [4:0]       cidx;
  logic             sc_c, sc_v;
  op_e              op;

  always_comb begin
    op       = op_e'(s1_type_q);
    cin      = flags_q.c;
    sum      = {1'b0, s1_src_q} + {1'b0, s1_dest_q};
    b_in     = s1_hi_q ? s1_dest_q[15:8] : s1_dest_q[7:0];
    b_out    = b_in + {7'd0, cin};

    cnt      = s1_src_q[CountW-1:0];
    right    = cnt[CountW-1];
    n_sh     = right ? (~cnt + 6'd1) : cnt;
    shl      = s1_dest_q << n_sh;
    shr      = WordW'($signed(s1_dest_q) >>> n_sh);
    ext      = {s1_dest_q, 16'd0};
    // top n+1 bits of the extended word: bit 15 takes each of these in turn
    win_mask = ~(32'hFFFF_FFFF >> ({26'd0, n_sh} + 32'd1));
    win      = ext & win_mask;
    cidx     = 5'(6'd32 - n_sh);
    sc_c     = 1'b0;
    sc_v     = 1'b0;
    if (n_sh != '0) begin
      if (right) begin
        sc_c = (n_sh > 6'd16) ? s1_dest_q[15] : s1_dest_q[4'(n_sh - 6'd1)];
      end else begin
        sc_c = ext[cidx];
        sc_v = (win != '0) && (win != win_mask);
      end
    end

    res_d   = s1_dest_q;
    flags_d = flags_q;
    case (op)
      OP_ADC: begin
        res_d     = s1_dest_q + {15'd0, cin};
        flags_d.v = (s1_dest_q == WordSMax) && cin;
        flags_d.c = (s1_dest_q == WordMax) && cin;
      end
      OP_ADC_BYTE: begin
        res_d     = s1_hi_q ? {b_out, s1_dest_q[7:0]} : {s1_dest_q[15:8], b_out};
        flags_d.v = (b_in == ByteSMax) && cin;
        flags_d.c = (b_in == ByteMax) && cin;
      end
      OP_ADD: begin
        res_d     = sum[WordW-1:0];
        flags_d.v = (s1_src_q[15] == s1_dest_q[15]) && (sum[15] != s1_src_q[15]);
        flags_d.c = sum[WordW];
      end
      OP_SHIFT_CNT: begin
        res_d     = right ? shr : shl;
        flags_d.v = sc_v;
        flags_d.c = sc_c;
      end
      OP_SHIFT_L: begin
        res_d     = {s1_dest_q[14:0], 1'b0};
        flags_d.c = s1_dest_q[15];
        flags_d.v = s1_dest_q[14] ^ s1_dest_q[15];
      end
      OP_SHIFT_R: begin
        res_d     = {s1_dest_q[15], s1_dest_q[15:1]};
        flags_d.c = s1_dest_q[0];
        flags_d.v = s1_dest_q[15] ^ s1_dest_q[0];
      end
      default: begin
      end
    endcase

    case (op) inside
      OP_ADC_BYTE: begin
        flags_d.n = b_out[7];
        flags_d.z = (b_out == 8'd0);
      end
      OP_ADC, OP_ADD, OP_SHIFT_CNT, OP_SHIFT_L, OP_SHIFT_R: begin
        flags_d.n = res_d[15];
        flags_d.z = (res_d == '0);
      end
      default: begin
      end
    endcase
  end

  // advance the flags together with the request they belong to
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        flags_q <= flags_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q  <= res_d;
      out_flags_q <= flags_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_word = out_word_q;
  assign rsp_o.n_flag      = out_flags_q.n;
  assign rsp_o.z_flag      = out_flags_q.z;
  assign rsp_o.v_flag      = out_flags_q.v;
  assign rsp_o.c_flag      = out_flags_q.c;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("request not ready with result stage empty");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without a request advancing");

  a_rsp_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("response appeared without a staged request");

  a_rsp_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_flags_q == flags_q))
    else $error("response flags differ from flag register");

endmodule

/* verif/alu_flag_checker.sv */
// ----------------------------------------------------------------------------
// alu_flag_checker: result predictor and scoreboard for the add/shift ALU
// Tracks the N, Z, V, C flags, predicts each result from accepted requests
// and compares every response in order, field by field.
// ----------------------------------------------------------------------------
module alu_flag_checker
  import mcalu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mcalu_req_if req_i,
  mcalu_rsp_if rsp_i,
  output int   fail_count_o,
  output int   pending_count_o
);

  typedef struct packed {
    logic [WordW-1:0] word;
    flags_t           fl;
  } alu_result_t;

  alu_result_t expected_q[$];
  alu_result_t predicted;
  alu_result_t oldest;
  flags_t      flags_now;
  int          mismatches = 0;

  function automatic alu_result_t compute_alu(logic [OpW-1:0] op, logic [WordW-1:0] d,
                                              logic [WordW-1:0] s, logic hi, flags_t cur);
    alu_result_t      res;
    logic [WordW:0]   sum;
    logic [WordW-1:0] w;
    logic [WordW-1:0] prev;
    logic [7:0]       b;
    logic [7:0]       rb;
    logic [CountW-1:0] cnt;
    logic             right;
    logic             cf;
    logic             vf;
    int               steps;
    int               i;
    res.word = d;
    res.fl   = cur;
    case (op)
      OP_ADC: begin
        w = d + WordW'(cur.c);
        res.word = w;
        res.fl.n = w[15];
        res.fl.z = (w == '0);
        res.fl.v = (d == WordSMax) && cur.c;
        res.fl.c = (d == WordMax) && cur.c;
      end
      OP_ADC_BYTE: begin
        b  = hi ? d[15:8] : d[7:0];
        rb = b + 8'(cur.c);
        res.word = hi ? {rb, d[7:0]} : {d[15:8], rb};
        res.fl.n = rb[7];
        res.fl.z = (rb == '0);
        res.fl.v = (b == ByteSMax) && cur.c;
        res.fl.c = (b == ByteMax) && cur.c;
      end
      OP_ADD: begin
        sum = {1'b0, s} + {1'b0, d};
        w   = sum[WordW-1:0];
        res.word = w;
        res.fl.n = w[15];
        res.fl.z = (w == '0);
        res.fl.v = (s[15] == d[15]) && (w[15] != s[15]);
        res.fl.c = sum[WordW];
      end
      OP_SHIFT_CNT: begin
        // negative counts shift right arithmetically; walk one place at a time
        cnt   = s[CountW-1:0];
        right = cnt[CountW-1];
        steps = right ? 64 - int'(cnt) : int'(cnt);
        w  = d;
        cf = 1'b0;
        vf = 1'b0;
        for (i = 0; i < steps; i++) begin
          prev = w;
          if (right) begin
            cf = w[0];
            w  = {w[15], w[15:1]};
          end else begin
            cf = w[15];
            w  = {w[14:0], 1'b0};
          end
          if (prev[15] != w[15]) vf = 1'b1;
        end
        res.word = w;
        res.fl.n = w[15];
        res.fl.z = (w == '0);
        res.fl.v = vf;
        res.fl.c = cf;
      end
      OP_SHIFT_L: begin
        cf = d[15];
        w  = {d[14:0], 1'b0};
        res.word = w;
        res.fl.n = w[15];
        res.fl.z = (w == '0);
        res.fl.v = w[15] ^ cf;
        res.fl.c = cf;
      end
      OP_SHIFT_R: begin
        cf = d[0];
        w  = {d[15], d[15:1]};
        res.word = w;
        res.fl.n = w[15];
        res.fl.z = (w == '0);
        res.fl.v = w[15] ^ cf;
        res.fl.c = cf;
      end
      default: begin
        // spare codes pass the word and hold the flags
        res.word = d;
        res.fl   = cur;
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string field, logic [WordW-1:0] want, logic [WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_now = '0;
      expected_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        predicted = compute_alu(req_i.req_type, req_i.dest_word, req_i.src_word,
                                req_i.byte_high, flags_now);
        flags_now = predicted.fl;
        expected_q.push_back(predicted);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual word %h flags %b%b%b%b",
                   $time, rsp_i.result_word, rsp_i.n_flag, rsp_i.z_flag,
                   rsp_i.v_flag, rsp_i.c_flag);
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("result_word", oldest.word, rsp_i.result_word);
          check_field("n_flag", WordW'(oldest.fl.n), WordW'(rsp_i.n_flag));
          check_field("z_flag", WordW'(oldest.fl.z), WordW'(rsp_i.z_flag));
          check_field("v_flag", WordW'(oldest.fl.v), WordW'(rsp_i.v_flag));
          check_field("c_flag", WordW'(oldest.fl.c), WordW'(rsp_i.c_flag));
        end
      end
    end
    fail_count_o    <= mismatches;
    pending_count_o <= expected_q.size();
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the add/shift ALU with condition flags
// Directed corner requests, then random requests with bursty request gaps
// and response stalls; the flag checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import mcalu_pkg::*;

  localparam logic [OpW-1:0] OpSpare6    = 3'd6;
  localparam logic [OpW-1:0] OpSpare7    = 3'd7;
  localparam int             RandomItems = 1700;
  localparam int             SteadyItems = 300;
  localparam int             IdleLimit   = 500;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  bit   steady_tail = 1'b0;
  int   idle_cycles = 0;

  mcalu_req_if req();
  mcalu_rsp_if rsp();

  minicomputer_add_shift_alu_flags dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  alu_flag_checker u_flag_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .rsp_i           (rsp),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Drive one request and hold it until it is taken.
  task automatic send_request(logic [OpW-1:0] op, logic [WordW-1:0] d,
                              logic [WordW-1:0] s, logic hi);
    req.valid     <= 1'b1;
    req.req_type  <= op;
    req.dest_word <= d;
    req.src_word  <= s;
    req.byte_high <= hi;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  function automatic logic [WordW-1:0] pick_operand();
    logic [WordW-1:0] w;
    w = WordW'($urandom);
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = WordMax;
      2: w = WordSMax;
      3: w = ~WordSMax;
      4: w[7:0] = $urandom_range(0, 1) ? ByteMax : ByteSMax;
      5: w[15:8] = $urandom_range(0, 1) ? ByteMax : ByteSMax;
      default: ;
    endcase
    return w;
  endfunction

  // response stalls in bursts, with calm windows
  initial begin
    int  stall_left;
    int  cyc;
    bit  calm;
    stall_left = 0;
    cyc = 0;
    calm = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (steady_tail || calm) begin
        stall_left = 0;
        rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [OpW-1:0]   op;
    logic [WordW-1:0] d;
    logic [WordW-1:0] s;
    bit               gaps_on;
    int               k;
    rst_ni        <= 1'b0;
    req.valid     <= 1'b0;
    req.req_type  <= OP_ADC;
    req.dest_word <= '0;
    req.src_word  <= '0;
    req.byte_high <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_request(OP_ADD,       16'hFFFF, 16'h0001, 1'b0);
    send_request(OP_ADC,       16'h7FFF, 16'h0000, 1'b0);
    send_request(OP_ADD,       16'h7FFF, 16'h0001, 1'b0);
    send_request(OP_ADD,       16'h8000, 16'h8000, 1'b1);
    send_request(OP_ADC,       16'hFFFF, 16'hFFFF, 1'b0);
    send_request(OP_ADC_BYTE,  16'h12FF, 16'h0000, 1'b0);
    send_request(OP_ADC_BYTE,  16'h7F34, 16'h0000, 1'b1);
    send_request(OP_ADC_BYTE,  16'hAB7F, 16'h0000, 1'b0);
    send_request(OP_SHIFT_L,   16'h8000, 16'h0000, 1'b0);
    send_request(OP_ADC_BYTE,  16'h347F, 16'h0000, 1'b0);
    send_request(OP_ADC_BYTE,  16'hFF00, 16'h0000, 1'b1);
    send_request(OP_SHIFT_CNT, 16'h8001, 16'hFFC0, 1'b0);
    send_request(OP_SHIFT_CNT, 16'h0001, 16'h001F, 1'b0);
    send_request(OP_SHIFT_CNT, 16'h8000, 16'h0020, 1'b0);
    send_request(OP_SHIFT_CNT, 16'h0003, 16'h003F, 1'b0);
    send_request(OP_SHIFT_CNT, 16'hFFFF, 16'h0010, 1'b0);
    send_request(OP_SHIFT_CNT, 16'h4000, 16'h0001, 1'b0);
    send_request(OP_SHIFT_CNT, 16'h5A5A, 16'hFFC5, 1'b1);
    send_request(OP_SHIFT_R,   16'h0001, 16'h0000, 1'b0);
    send_request(OP_SHIFT_R,   16'h8000, 16'h0000, 1'b0);
    send_request(OpSpare6,     16'h1234, 16'h5678, 1'b0);
    send_request(OpSpare7,     16'hFFFF, 16'hFFFF, 1'b1);
    send_request(OP_ADD,       16'hFFFF, 16'hFFFF, 1'b0);
    send_request(OP_ADC,       16'h0000, 16'h0000, 1'b0);
    drain_results();

    // random requests
    gaps_on = 1'b1;
    for (k = 0; k < RandomItems; k++) begin
      if (k == RandomItems - SteadyItems) steady_tail = 1'b1;
      if (k % 100 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (k == 600 || k == 1200) drain_results();
      if ($urandom_range(0, 19) == 0) begin
        op = $urandom_range(0, 1) ? OpSpare6 : OpSpare7;
      end else begin
        op = OpW'($urandom_range(OP_ADC, OP_SHIFT_R));
      end
      d = pick_operand();
      s = pick_operand();
      if (op == OP_SHIFT_CNT && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: s[CountW-1:0] = 6'd0;
          1: s[CountW-1:0] = 6'd31;
          2: s[CountW-1:0] = 6'd32;
          default: s[CountW-1:0] = 6'd16;
        endcase
      end
      send_request(op, d, s, 1'($urandom_range(0, 1)));
      if (!steady_tail && gaps_on && $urandom_range(0, 6) == 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
